### design/smep_pkg.sv
// Shared types and constants for the symbolic mode expression parser.
`default_nettype none

package smep_pkg;

    // Class selection bits (user, group, other)
    localparam logic [2:0] CLS_U   = 3'h1;
    localparam logic [2:0] CLS_G   = 3'h2;
    localparam logic [2:0] CLS_O   = 3'h4;
    localparam logic [2:0] CLS_ALL = 3'h7;

    // Operator codes
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_SUB  = 2'd2;
    localparam logic [1:0] OP_SET  = 2'd3;

    // Permission bits within one class
    localparam logic [2:0] PERM_R = 3'd4;
    localparam logic [2:0] PERM_W = 3'd2;
    localparam logic [2:0] PERM_X = 3'd1;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // Parse state carried from one character to the next
    typedef struct packed {
        logic [11:0] saved_base;
        logic [11:0] work_mode;
        logic [2:0]  class_set;
        logic [1:0]  operator_kind;
        logic        perm_phase;     // 0: class list, 1: permission letters
        logic        letters_seen;
        logic        error_seen;
        logic        any_char_seen;
    } parse_state_t;

endpackage

`default_nettype wire

### design/smep_step.sv
// Next-state and result logic for one expression character.
`default_nettype none

module smep_step (
    input  smep_pkg::parse_state_t cur,
    input  logic                   start_req,
    input  logic [11:0]            base_mode,
    input  logic [7:0]             char_code,
    output smep_pkg::parse_state_t nxt,
    output logic                   res_done,
    output logic [11:0]            res_mode,
    output logic                   res_error
);
    import smep_pkg::*;

    // Replicate a 3-bit permission value into every selected class
    function automatic logic [11:0] spread(input logic [2:0] bits3, input logic [2:0] classes);
        logic [11:0] v;
        v = 12'h000;
        if ((classes & CLS_U) != 3'd0) v[8:6] = bits3;
        if ((classes & CLS_G) != 3'd0) v[5:3] = bits3;
        if ((classes & CLS_O) != 3'd0) v[2:0] = bits3;
        return v;
    endfunction

    // Return parse state to the start of an expression
    function automatic parse_state_t clear_parse(input parse_state_t s);
        parse_state_t r;
        r               = s;
        r.work_mode     = s.saved_base;
        r.class_set     = 3'd0;
        r.operator_kind = OP_NONE;
        r.perm_phase    = 1'b0;
        r.letters_seen  = 1'b0;
        r.error_seen    = 1'b0;
        r.any_char_seen = 1'b0;
        return r;
    endfunction

    parse_state_t s;
    logic         bad;
    logic [2:0]   perm_bit;
    logic [2:0]   cls;

    always_comb
    begin
        s         = cur;
        bad       = 1'b0;
        perm_bit  = 3'd0;
        cls       = 3'd0;
        res_done  = 1'b0;
        res_mode  = 12'h000;
        res_error = 1'b0;

        // A new expression loads the base mode first
        if (start_req)
        begin
            s.saved_base = base_mode;
            s = clear_parse(s);
        end

        if (char_code == CH_NUL)
        begin
            // Terminator: judge the expression and emit the word
            bad = s.error_seen || !s.any_char_seen || !s.perm_phase ||
                  (!s.letters_seen && s.operator_kind != OP_SET);
            res_done  = 1'b1;
            res_mode  = bad ? s.saved_base : s.work_mode;
            res_error = bad;
            s = clear_parse(s);
        end
        else
        begin
            s.any_char_seen = 1'b1;
            if (!s.error_seen)
            begin
                if (s.perm_phase)
                begin
                    // Permission letter phase
                    case (char_code)
                        CH_COMMA:
                        begin
                            if (!s.letters_seen && s.operator_kind != OP_SET)
                                s.error_seen = 1'b1;
                            else
                            begin
                                s.class_set     = 3'd0;
                                s.operator_kind = OP_NONE;
                                s.letters_seen  = 1'b0;
                                s.perm_phase    = 1'b0;
                            end
                        end
                        CH_R, CH_W, CH_X:
                        begin
                            if (char_code == CH_R)
                                perm_bit = PERM_R;
                            else if (char_code == CH_W)
                                perm_bit = PERM_W;
                            else
                                perm_bit = PERM_X;
                            s.letters_seen = 1'b1;
                            if (s.operator_kind == OP_SUB)
                                s.work_mode = s.work_mode & ~spread(perm_bit, s.class_set);
                            else
                                s.work_mode = s.work_mode | spread(perm_bit, s.class_set);
                        end
                        default:
                            s.error_seen = 1'b1;
                    endcase
                end
                else
                begin
                    // Class list phase
                    case (char_code)
                        CH_U: s.class_set = s.class_set | CLS_U;
                        CH_G: s.class_set = s.class_set | CLS_G;
                        CH_O: s.class_set = s.class_set | CLS_O;
                        CH_A: s.class_set = CLS_ALL;
                        CH_PLUS, CH_MINUS, CH_EQ:
                        begin
                            cls = (s.class_set == 3'd0) ? CLS_ALL : s.class_set;
                            s.class_set = cls;
                            if (char_code == CH_PLUS)
                                s.operator_kind = OP_ADD;
                            else if (char_code == CH_MINUS)
                                s.operator_kind = OP_SUB;
                            else
                            begin
                                s.operator_kind = OP_SET;
                                s.work_mode = s.work_mode & ~spread(CLS_ALL, cls);
                            end
                            s.letters_seen = 1'b0;
                            s.perm_phase   = 1'b1;
                        end
                        default:
                            s.error_seen = 1'b1;
                    endcase
                end
            end
        end

        nxt = s;
    end

endmodule

`default_nettype wire

### design/symbolic_mode_expression_parser_core.sv
// A character word is held in the input register; the parse step then updates the
//   state register and, for a terminator, loads the result register behind result_valid.
// Throughput: one character per cycle, set by the combinational parse step that
//   updates the state register; a terminator waits only while a result word is stalled.
// Reset (rst_n low, asynchronous): parse state clears to class-list phase with
//   zero base and work mode; no words are held in the input or result register.
`default_nettype none

module symbolic_mode_expression_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire logic        start_req,
    input  wire logic [11:0] base_mode,
    input  wire logic [7:0]  char_code,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [11:0]      new_mode,
    output logic             error
);
    import smep_pkg::*;

    // Input register
    logic        in_valid_reg;
    logic        in_valid_next;
    logic        start_reg;
    logic [11:0] base_reg;
    logic [7:0]  char_reg;

    // Parse state and result register
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [11:0]  mode_reg;
    logic         error_reg;

    logic         res_done;
    logic [11:0]  res_mode;
    logic         res_error;
    logic         is_term;
    logic         advance;

    smep_step u_step (
        .cur       (state_reg),
        .start_req (start_reg),
        .base_mode (base_reg),
        .char_code (char_reg),
        .nxt       (state_next),
        .res_done  (res_done),
        .res_mode  (res_mode),
        .res_error (res_error)
    );

    // A terminator may only advance when the result register can take it
    assign is_term    = (char_reg == CH_NUL);
    assign advance    = in_valid_reg && (!is_term || !out_valid_reg || !result_stall);
    assign char_stall = in_valid_reg && !advance;

    assign in_valid_next  = char_stall ? in_valid_reg : char_valid;
    assign out_valid_next = (advance && res_done) ? 1'b1 :
                            (result_stall ? out_valid_reg : 1'b0);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Input word payload
    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            start_reg <= start_req;
            base_reg  <= base_mode;
            char_reg  <= char_code;
        end
    end

    // Result word payload
    always_ff @(posedge clk)
    begin
        if (advance && res_done)
        begin
            mode_reg  <= res_mode;
            error_reg <= res_error;
        end
    end

    assign result_valid = out_valid_reg;
    assign new_mode     = mode_reg;
    assign error        = error_reg;

endmodule

`default_nettype wire

### sim/symbolic_mode_expression_parser_core_test.sv
// Self-checking testbench for the symbolic mode expression parser core.
`timescale 1ns / 1ps

module symbolic_mode_expression_parser_core_test;
    import smep_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [7:0] CLASS_CHARS [0:3] = '{CH_U, CH_G, CH_O, CH_A};
    localparam logic [7:0] OP_CHARS [0:2]    = '{CH_PLUS, CH_MINUS, CH_EQ};
    localparam logic [7:0] PERM_CHARS [0:2]  = '{CH_R, CH_W, CH_X};

    typedef struct packed {
        logic        start;
        logic [11:0] base;
        logic [7:0]  code;
    } char_word_t;

    typedef struct packed {
        logic [11:0] mode;
        logic        bad;
    } mode_result_t;

    logic        clk;
    logic        rst_n;
    logic        char_valid = 1'b0;
    logic        char_stall;
    logic        start_req = 1'b0;
    logic [11:0] base_mode = '0;
    logic [7:0]  char_code = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [11:0] new_mode;
    logic        error;

    // Stimulus and expectation stores
    char_word_t   char_words[$];
    mode_result_t expected_modes[$];
    logic [7:0]   expr_text[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_phase   = 1'b0;
    logic hold_on      = 1'b0;

    int cycle_count  = 0;
    int chars_queued = 0;
    int chars_taken  = 0;
    int results_seen = 0;
    int bad_seen     = 0;
    int failures     = 0;

    // Predicted parse state
    logic [11:0] pm_base       = '0;
    logic [11:0] pm_mode       = '0;
    logic [2:0]  pm_classes    = '0;
    logic [1:0]  pm_op         = OP_NONE;
    logic        pm_in_letters = 1'b0;
    logic        pm_got_letter = 1'b0;
    logic        pm_bad        = 1'b0;
    logic        pm_any        = 1'b0;

    symbolic_mode_expression_parser_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .start_req    (start_req),
        .base_mode    (base_mode),
        .char_code    (char_code),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .new_mode     (new_mode),
        .error        (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Copy a 3-bit permission set into each selected class field
    function automatic logic [11:0] fan_out(input logic [2:0] bits, input logic [2:0] classes);
        logic [11:0] v;
        v = '0;
        if ((classes & CLS_U) != 0) v[8:6] = bits;
        if ((classes & CLS_G) != 0) v[5:3] = bits;
        if ((classes & CLS_O) != 0) v[2:0] = bits;
        return v;
    endfunction

    task automatic restart_expression();
        pm_mode       = pm_base;
        pm_classes    = '0;
        pm_op         = OP_NONE;
        pm_in_letters = 1'b0;
        pm_got_letter = 1'b0;
        pm_bad        = 1'b0;
        pm_any        = 1'b0;
    endtask

    // Advance the predicted parse by one accepted character word
    task automatic predict_char(input char_word_t w);
        mode_result_t r;
        logic [2:0]   bit_sel;
        if (w.start)
        begin
            pm_base = w.base;
            restart_expression();
        end
        if (w.code == CH_NUL)
        begin
            r.bad  = pm_bad || !pm_any || !pm_in_letters || (!pm_got_letter && pm_op != OP_SET);
            r.mode = r.bad ? pm_base : pm_mode;
            expected_modes.push_back(r);
            restart_expression();
        end
        else
        begin
            pm_any = 1'b1;
            if (!pm_bad && !pm_in_letters)
            begin
                // class list: who, then the operator
                case (w.code)
                    CH_U: pm_classes |= CLS_U;
                    CH_G: pm_classes |= CLS_G;
                    CH_O: pm_classes |= CLS_O;
                    CH_A: pm_classes |= CLS_ALL;
                    CH_PLUS, CH_MINUS, CH_EQ:
                    begin
                        if (pm_classes == '0) pm_classes = CLS_ALL;
                        pm_op = (w.code == CH_PLUS) ? OP_ADD :
                                (w.code == CH_MINUS) ? OP_SUB : OP_SET;
                        if (pm_op == OP_SET)
                            pm_mode &= ~fan_out(PERM_R | PERM_W | PERM_X, pm_classes);
                        pm_got_letter = 1'b0;
                        pm_in_letters = 1'b1;
                    end
                    default: pm_bad = 1'b1;
                endcase
            end
            else if (!pm_bad)
            begin
                // permission letters or end of clause
                bit_sel = '0;
                case (w.code)
                    CH_COMMA:
                    begin
                        if (!pm_got_letter && pm_op != OP_SET)
                            pm_bad = 1'b1;
                        else
                        begin
                            pm_classes    = '0;
                            pm_op         = OP_NONE;
                            pm_got_letter = 1'b0;
                            pm_in_letters = 1'b0;
                        end
                    end
                    CH_R: bit_sel = PERM_R;
                    CH_W: bit_sel = PERM_W;
                    CH_X: bit_sel = PERM_X;
                    default: pm_bad = 1'b1;
                endcase
                if (bit_sel != '0)
                begin
                    pm_got_letter = 1'b1;
                    if (pm_op == OP_SUB)
                        pm_mode &= ~fan_out(bit_sel, pm_classes);
                    else
                        pm_mode |= fan_out(bit_sel, pm_classes);
                end
            end
        end
    endtask

    task automatic note_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        failures++;
    endtask

    // Compare one result word against the oldest prediction
    task automatic check_result(input logic [11:0] mode, input logic bad);
        mode_result_t want;
        results_seen++;
        if (bad) bad_seen++;
        if (expected_modes.size() == 0)
            note_mismatch($sformatf("unexpected result word mode=%03h error=%0b", mode, bad));
        else
        begin
            want = expected_modes.pop_front();
            if (mode !== want.mode)
                note_mismatch($sformatf("new_mode %03h, expected %03h", mode, want.mode));
            if (bad !== want.bad)
                note_mismatch($sformatf("error %0b, expected %0b", bad, want.bad));
        end
    endtask

    // Queue expr_text as character words plus terminator
    task automatic queue_expression(input logic fresh, input logic [11:0] base, input bit restarts);
        char_word_t w;
        for (int i = 0; i < expr_text.size(); i++)
        begin
            w.start = fresh && (i == 0);
            w.base  = w.start ? base : 12'($urandom);
            w.code  = expr_text[i];
            if (restarts && i > 0 && $urandom_range(0, 39) == 0)
                w.start = 1'b1;
            char_words.push_back(w);
        end
        w.start = fresh && (expr_text.size() == 0);
        w.base  = w.start ? base : 12'($urandom);
        w.code  = CH_NUL;
        char_words.push_back(w);
        chars_queued += expr_text.size() + 1;
        expr_text.delete();
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            expr_text.push_back(s[i]);
    endtask

    // Random expressions, mostly well formed, then drain
    task automatic run_phase(input int idle_pct, input int stall_pct, input int quota);
        int         target;
        int         n;
        int         pos;
        logic [7:0] op;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = chars_queued + quota;
        while (chars_queued < target)
        begin
            for (int c = $urandom_range(1, 3); c > 0; c--)
            begin
                if (expr_text.size() != 0) expr_text.push_back(CH_COMMA);
                n = $urandom_range(0, 3);
                repeat (n) expr_text.push_back(CLASS_CHARS[$urandom_range(0, 3)]);
                op = OP_CHARS[$urandom_range(0, 2)];
                expr_text.push_back(op);
                n = $urandom_range((op == CH_EQ) ? 0 : 1, 3);
                repeat (n) expr_text.push_back(PERM_CHARS[$urandom_range(0, 2)]);
            end
            // break about a quarter of them
            if ($urandom_range(0, 99) < 25)
            begin
                pos = $urandom_range(0, expr_text.size() - 1);
                case ($urandom_range(0, 4))
                    0: expr_text[pos] = 8'($urandom_range(1, 255));
                    1: expr_text.delete(pos);
                    2: expr_text.push_back(CH_COMMA);
                    3: expr_text.delete();
                    default: expr_text.insert(pos, 8'($urandom_range(1, 255)));
                endcase
            end
            queue_expression($urandom_range(0, 9) != 0, 12'($urandom), 1'b1);
        end
        while (char_words.size() != 0 || char_valid || expected_modes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Character word driver
    always @(posedge clk or negedge rst_n)
    begin : drive_chars
        char_word_t taken_w;
        char_word_t next_w;
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            start_req  <= 1'b0;
            base_mode  <= '0;
            char_code  <= '0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                taken_w.start = start_req;
                taken_w.base  = base_mode;
                taken_w.code  = char_code;
                predict_char(taken_w);
                chars_taken++;
            end
            if (!char_valid || !char_stall)
            begin
                if (char_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_w = char_words.pop_front();
                    char_valid <= 1'b1;
                    start_req  <= next_w.start;
                    base_mode  <= next_w.base;
                    char_code  <= next_w.code;
                end
                else
                    char_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
                check_result(new_mode, error);
            result_stall <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Long receiver hold-off for back-pressure
    initial
    begin
        wait (hold_phase);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout at cycle %0d, %0d results outstanding", cycle_count,
                     expected_modes.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty expression
        queue_expression(1'b1, 12'hFFF, 1'b0);
        // no class letters means all classes
        load_text("+x");
        queue_expression(1'b1, 12'h000, 1'b0);
        load_text("a=");
        queue_expression(1'b1, 12'hFFF, 1'b0);
        // minus, then equals with no letters
        load_text("u-r,g=");
        queue_expression(1'b1, 12'h5A5, 1'b0);
        // missing operator, no restart: reuses previous base
        load_text("o");
        expr_text.push_back(8'hFF);
        queue_expression(1'b0, 12'h000, 1'b0);
        // bad letter
        load_text("u+q");
        queue_expression(1'b1, 12'h123, 1'b0);
        // minus with no letters
        load_text("g-");
        queue_expression(1'b1, 12'hE38, 1'b0);
        // trailing comma
        load_text("u+r,");
        queue_expression(1'b1, 12'h800, 1'b0);
        run_phase(0, 0, 0);

        run_phase(0, 0, 400);
        run_phase(67, 0, 400);
        run_phase(0, 67, 400);
        run_phase(17, 17, 400);
        hold_phase = 1'b1;
        run_phase(0, 0, 250);

        $display("Covered %0d characters and %0d results (%0d malformed) over free-running,",
                 chars_taken, results_seen, bad_seen);
        $display("  sender-idle, receiver-stall, mixed and long hold-off phases");
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
design/smep_pkg.sv
design/smep_step.sv
design/symbolic_mode_expression_parser_core.sv
sim/symbolic_mode_expression_parser_core_test.sv
